// File: design/snt_pkg.sv
// Shared types, codes and sizing constants for the sorted node table.
// Used by the node cell and the top level; depends on nothing else.
package snt_pkg;

    localparam int SNT_MAX_ENTRIES  = 64;
    localparam int SNT_KEY_WIDTH    = 64;
    localparam int SNT_VALUE_WIDTH  = 64;

    localparam int SNT_FIELD_WIDTH  = 64;
    localparam int SNT_CNT_OUT_W    = 7;
    localparam int SNT_CFG_IDX_W    = 2;
    localparam int SNT_CFG_DATA_W   = 7;

    localparam logic [6:0] SNT_MAX_KEYS_RESET = 7'd64;
    localparam logic [6:0] SNT_MIN_KEYS_RESET = 7'd32;

    // Request kinds.
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_FIND   = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DUP       = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW = 3'd4;

    // Configuration register indexes.
    localparam logic [SNT_CFG_IDX_W-1:0] CFG_MAX_KEYS = 2'd0;
    localparam logic [SNT_CFG_IDX_W-1:0] CFG_MIN_KEYS = 2'd1;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [SNT_FIELD_WIDTH-1:0] key;
        logic [SNT_FIELD_WIDTH-1:0] value;
    } snt_req_t;

    typedef struct packed {
        logic [2:0]                 status;
        logic [SNT_FIELD_WIDTH-1:0] found_value;
        logic [SNT_CNT_OUT_W-1:0]   position;
        logic [SNT_CNT_OUT_W-1:0]   count_after;
    } snt_rsp_t;

    // Per-cycle commands broadcast to every cell of the chain.
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic del_en;
    } snt_cell_ctrl_t;

endpackage

// File: design/sorted_node_table.sv
// Sorted node table: one B-tree node as a chain of key/value cells.
// Each request is compared on accept and then settled; no new request is accepted until the last one settles.
// The compare runs in all cells in the accept cycle; the shift, count and result settle next.
// A result held by a stalled consumer delays the settle cycle of the following request.
// Reset (aresetn, synchronous, low) empties the node and restores max_keys 64, min_keys 32.
module sorted_node_table
    import snt_pkg::*;
#(
    parameter int MAX_ENTRIES = SNT_MAX_ENTRIES,
    parameter int KEY_WIDTH   = SNT_KEY_WIDTH,
    parameter int VALUE_WIDTH = SNT_VALUE_WIDTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  snt_req_t                  s_payload,
    output logic                      m_valid,
    input  logic                      m_ready,
    output snt_rsp_t                  m_payload,
    input  logic                      cfg_we,
    input  logic [SNT_CFG_IDX_W-1:0]  cfg_index,
    input  logic [SNT_CFG_DATA_W-1:0] cfg_wdata
);

    // Count and position both range over 0..MAX_ENTRIES.
    localparam int PW = $clog2(MAX_ENTRIES + 1);
    // Wide enough to compare the count against the 7-bit registers.
    localparam int CW = (PW > SNT_CFG_DATA_W) ? PW : SNT_CFG_DATA_W;

    // Control and configuration state.
    logic                      busy_reg, busy_next;
    logic [PW-1:0]             count_reg, count_next;
    logic [SNT_CFG_DATA_W-1:0] max_keys_reg, max_keys_next;
    logic [SNT_CFG_DATA_W-1:0] min_keys_reg, min_keys_next;
    logic                      m_valid_reg, m_valid_next;

    // Request held for the settle cycle, and the result register.
    logic [1:0]             kind_reg;
    logic [KEY_WIDTH-1:0]   req_key_reg;
    logic [VALUE_WIDTH-1:0] req_value_reg;
    snt_rsp_t               rsp_reg, rsp_next;

    logic accept;
    logic fire;

    snt_cell_ctrl_t         cell_ctrl;
    logic [KEY_WIDTH-1:0]   in_key;
    logic [KEY_WIDTH-1:0]   cell_key   [MAX_ENTRIES];
    logic [VALUE_WIDTH-1:0] cell_value [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] lt_vec;
    logic [MAX_ENTRIES-1:0] eq_vec;

    // Decode of the settle cycle.
    logic [MAX_ENTRIES:0]   boundary;
    logic [PW-1:0]          pos;
    logic                   hit;
    logic [VALUE_WIDTH-1:0] hit_value;
    logic [CW-1:0]          cnt_ext;
    logic [CW-1:0]          cap_ext;
    logic                   full;
    logic                   underflow;

    // A new request enters only when the previous one has settled; the
    // comparison happens in the same edge that accepts it.
    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    // The settle cycle waits only while the output register still holds an
    // unclaimed result.
    assign fire    = busy_reg && (!m_valid_reg || m_ready);
    assign in_key  = s_payload.key[KEY_WIDTH-1:0];

    // The chain of cells. Each cell looks at its left neighbor for insert
    // shifts and its right neighbor for delete shifts; the ends are tied off.
    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
        logic                   left_lt;
        logic [KEY_WIDTH-1:0]   left_key;
        logic [VALUE_WIDTH-1:0] left_value;
        logic [KEY_WIDTH-1:0]   right_key;
        logic [VALUE_WIDTH-1:0] right_value;

        if (gi == 0) begin : g_left_end
            assign left_lt    = 1'b1;
            assign left_key   = '0;
            assign left_value = '0;
        end else begin : g_left
            assign left_lt    = lt_vec[gi-1];
            assign left_key   = cell_key[gi-1];
            assign left_value = cell_value[gi-1];
        end

        if (gi == MAX_ENTRIES - 1) begin : g_right_end
            assign right_key   = '0;
            assign right_value = '0;
        end else begin : g_right
            assign right_key   = cell_key[gi+1];
            assign right_value = cell_value[gi+1];
        end

        snt_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (cell_ctrl),
            .slot_valid  (count_reg > PW'(gi)),
            .cmp_key     (in_key),
            .new_key     (req_key_reg),
            .new_value   (req_value_reg),
            .left_lt     (left_lt),
            .left_key    (left_key),
            .left_value  (left_value),
            .right_key   (right_key),
            .right_value (right_value),
            .key_out     (cell_key[gi]),
            .value_out   (cell_value[gi]),
            .lt_out      (lt_vec[gi]),
            .eq_out      (eq_vec[gi])
        );
    end

    // Keys are sorted, so the "below" flags form a run from slot zero. The
    // slot position is the single place where that run ends, and at most one
    // cell can match the key, so both reduce to one-hot selections.
    assign boundary = ~{1'b0, lt_vec} & {lt_vec, 1'b1};
    assign hit      = |eq_vec;

    always_comb begin
        pos       = '0;
        hit_value = '0;
        for (int i = 0; i <= MAX_ENTRIES; i++) begin
            if (boundary[i]) begin
                pos = pos | PW'(i);
            end
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (eq_vec[i]) begin
                hit_value = hit_value | cell_value[i];
            end
        end
    end

    // Capacity is the smaller of max_keys and the physical depth.
    assign cnt_ext   = CW'(count_reg);
    assign cap_ext   = (CW'(max_keys_reg) < CW'(MAX_ENTRIES)) ? CW'(max_keys_reg)
                                                              : CW'(MAX_ENTRIES);
    assign full      = cnt_ext >= cap_ext;
    assign underflow = cnt_ext <= CW'(min_keys_reg);

    always_comb begin
        cell_ctrl        = '0;
        cell_ctrl.cmp_en = accept;
        busy_next        = busy_reg;
        count_next       = count_reg;
        rsp_next         = rsp_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        max_keys_next    = max_keys_reg;
        min_keys_next    = min_keys_reg;

        if (cfg_we) begin
            case (cfg_index)
                CFG_MAX_KEYS: max_keys_next = cfg_wdata;
                CFG_MIN_KEYS: min_keys_next = cfg_wdata;
                default: ;
            endcase
        end

        if (accept) begin
            busy_next = 1'b1;
        end

        if (fire) begin
            busy_next            = 1'b0;
            m_valid_next         = 1'b1;
            rsp_next.status      = ST_OK;
            rsp_next.found_value = '0;
            case (kind_reg)
                KIND_INSERT: begin
                    if (full) begin
                        rsp_next.status = ST_FULL;
                    end else if (hit) begin
                        rsp_next.status = ST_DUP;
                    end else begin
                        cell_ctrl.ins_en = 1'b1;
                        count_next       = count_reg + 1'b1;
                    end
                end
                KIND_DELETE: begin
                    if (!hit) begin
                        rsp_next.status = ST_NOT_FOUND;
                    end else if (underflow) begin
                        rsp_next.status = ST_UNDERFLOW;
                    end else begin
                        cell_ctrl.del_en = 1'b1;
                        count_next       = count_reg - 1'b1;
                    end
                end
                default: begin
                    // Find, and the unused kind code treated the same way.
                    if (!hit) begin
                        rsp_next.status = ST_NOT_FOUND;
                    end else begin
                        rsp_next.found_value = SNT_FIELD_WIDTH'(hit_value);
                    end
                end
            endcase
            rsp_next.position    = SNT_CNT_OUT_W'(pos);
            rsp_next.count_after = SNT_CNT_OUT_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            count_reg    <= '0;
            max_keys_reg <= SNT_MAX_KEYS_RESET;
            min_keys_reg <= SNT_MIN_KEYS_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            count_reg    <= count_next;
            max_keys_reg <= max_keys_next;
            min_keys_reg <= min_keys_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg      <= s_payload.kind;
            req_key_reg   <= in_key;
            req_value_reg <= s_payload.value[VALUE_WIDTH-1:0];
        end
        rsp_reg <= rsp_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = rsp_reg;

    // The entry count never passes the physical depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= PW'(MAX_ENTRIES))
        else $error("entry count beyond node depth");

    // With sorted, distinct keys at most one cell can match a request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> $onehot0(eq_vec))
        else $error("more than one cell matches the key");

    // The below-key flags must be a run starting at slot zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> ((lt_vec & ~{lt_vec[MAX_ENTRIES-2:0], 1'b1}) == '0))
        else $error("cells out of key order");

    // The count only moves on a settle cycle, and then by at most one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(count_reg))
        else $error("entry count changed outside a settle cycle");

    // An accepted request always occupies the settle stage next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (busy_reg && !s_ready))
        else $error("accepted request lost before settling");

endmodule

// File: design/snt_cell.sv
// One slot of the sorted node: holds a key/value pair and its compare flags.
// Depends on snt_pkg for the broadcast command struct.
module snt_cell
    import snt_pkg::*;
#(
    parameter int KEY_WIDTH   = SNT_KEY_WIDTH,
    parameter int VALUE_WIDTH = SNT_VALUE_WIDTH
) (
    input  logic                   aclk,
    input  snt_cell_ctrl_t         ctrl,
    input  logic                   slot_valid,
    input  logic [KEY_WIDTH-1:0]   cmp_key,
    input  logic [KEY_WIDTH-1:0]   new_key,
    input  logic [VALUE_WIDTH-1:0] new_value,
    input  logic                   left_lt,
    input  logic [KEY_WIDTH-1:0]   left_key,
    input  logic [VALUE_WIDTH-1:0] left_value,
    input  logic [KEY_WIDTH-1:0]   right_key,
    input  logic [VALUE_WIDTH-1:0] right_value,
    output logic [KEY_WIDTH-1:0]   key_out,
    output logic [VALUE_WIDTH-1:0] value_out,
    output logic                   lt_out,
    output logic                   eq_out
);

    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   lt_reg;
    logic                   eq_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.cmp_en) begin
            lt_reg <= slot_valid && (key_reg < cmp_key);
            eq_reg <= slot_valid && (key_reg == cmp_key);
        end
        // Cells at or above the slot position move: up on insert, down on delete.
        if (ctrl.ins_en && !lt_reg) begin
            if (left_lt) begin
                key_reg   <= new_key;
                value_reg <= new_value;
            end else begin
                key_reg   <= left_key;
                value_reg <= left_value;
            end
        end else if (ctrl.del_en && !lt_reg) begin
            key_reg   <= right_key;
            value_reg <= right_value;
        end
    end

    assign key_out   = key_reg;
    assign value_out = value_reg;
    assign lt_out    = lt_reg;
    assign eq_out    = eq_reg;

endmodule
